/* rtl/spd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg
// Types, codes and constants of the sync-word packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int TYPE_COUNT_DEF = 16;
  localparam int HEADER_BYTES   = 4;
  localparam int SEQ_BYTES      = 2;
  localparam int COUNT_ADJ      = SEQ_BYTES - HEADER_BYTES;

  localparam logic [7:0] SYNC_A_BYTE = 8'hAA;
  localparam logic [7:0] SYNC_B_BYTE = 8'h55;
  // payload starts after type and size in the packet buffer
  localparam logic [7:0] FIRST_OFFSET = 8'd2;

  typedef enum logic [1:0] {
    FUNC_BYTE      = 2'd0,
    FUNC_INSTALL   = 2'd1,
    FUNC_UNINSTALL = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_UNSYNC    = 4'd0,
    ST_SYNCA     = 4'd1,
    ST_SYNCB     = 4'd2,
    ST_TYPE      = 4'd3,
    ST_UNKNOWN   = 4'd4,
    ST_BADSIZE   = 4'd5,
    ST_SIZE      = 4'd6,
    ST_PAYLOAD   = 4'd7,
    ST_DONE      = 4'd8,
    ST_CRCOK     = 4'd9,
    ST_CRCERR    = 4'd10,
    ST_OK        = 4'd11,
    ST_RANGE     = 4'd12,
    ST_INSTERR   = 4'd13,
    ST_UNINSTERR = 4'd14
  } status_e;

  typedef enum logic [2:0] {
    PH_SYNC_A  = 3'd0,
    PH_SYNC_B  = 3'd1,
    PH_TYPE    = 3'd2,
    PH_SIZE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_value;
    logic [7:0] type_id;
    logic [7:0] size_value;
    logic       any_size;
  } in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] data_byte;
    logic [7:0] byte_offset;
    logic [7:0] packet_type;
  } out_t;

  // table write from the commit stage
  typedef struct packed {
    logic       install;
    logic       remove;
    logic [7:0] addr;
    logic       any_size;
    logic [7:0] size;
  } tbl_wr_t;

  // one table entry as seen by the commit stage
  typedef struct packed {
    logic       used;
    logic       any_size;
    logic [7:0] size;
  } slot_t;

endpackage
`default_nettype wire

/* rtl/spd_type_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spd_type_table
// Installed-type table: used bits in flops, size entries in a synchronous
// RAM with a registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module spd_type_table #(
  parameter int TYPE_COUNT = spd_pkg::TYPE_COUNT_DEF,
  localparam int AW = $clog2(TYPE_COUNT)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [7:0]      rd_addr_i,
  input  wire logic [7:0]      chk_addr_i,
  input  wire spd_pkg::tbl_wr_t wr_i,
  output spd_pkg::slot_t       slot_o
);
  import spd_pkg::*;

  logic [8:0]            mem_q [TYPE_COUNT];
  logic [8:0]            rdata_q;
  logic [TYPE_COUNT-1:0] used_q;
  logic [TYPE_COUNT-1:0] used_d;
  logic                  fwd_hit_q;
  logic [8:0]            fwd_data_q;
  logic [8:0]            wdata;
  logic [8:0]            entry;

  assign wdata = {wr_i.any_size, wr_i.size};

  always_ff @(posedge clk_i) begin
    if (wr_i.install) begin
      mem_q[wr_i.addr[AW-1:0]] <= wdata;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i[AW-1:0]];
    end
  end

  // a write landing on the edge of the read is caught here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_i.install && (wr_i.addr[AW-1:0] == rd_addr_i[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wdata;
    end
  end

  always_comb begin
    used_d = used_q;
    if (wr_i.install) begin
      used_d[wr_i.addr[AW-1:0]] = 1'b1;
    end
    if (wr_i.remove) begin
      used_d[wr_i.addr[AW-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign entry           = fwd_hit_q ? fwd_data_q : rdata_q;
  assign slot_o.used     = used_q[chk_addr_i[AW-1:0]];
  assign slot_o.any_size = entry[8];
  assign slot_o.size     = entry[7:0];

endmodule
`default_nettype wire

/* rtl/sync_packet_deframer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sync_packet_deframer_top
// Byte-serial frame receiver (AA 55 type size payload xor) with type table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_i carries one request per
//   cycle unless stalled: a line byte, an install or uninstall of a packet type.
//   Output channel out_valid_o / out_stall_i / out_o returns one status per
//   request, in order, with the payload byte and its buffer offset when the
//   request was a payload byte, and the current packet type.
//   Path: a request taken at the input is held in the commit stage (s1_q)
//   and then registered into out_q, from which out_o presents it.
//   Throughput: one request per cycle while the output is not stalled; the
//   table RAM is read at accept and the entry is used in the commit cycle,
//   with a write forwarded when the previous request edited the same type.
//   Stall: a valid result holds in out_q while out_stall_i is high; one more
//   request may wait in the commit stage, after which in_stall_o rises.
//   Reset: all types uninstalled at once (flop used bits, no clearing pass),
//   frame walk waits for the first sync byte, both stages empty.
// ----------------------------------------------------------------------------
module sync_packet_deframer_top #(
  parameter int TYPE_COUNT = spd_pkg::TYPE_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire spd_pkg::in_t in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output spd_pkg::out_t    out_o
);
  import spd_pkg::*;

  localparam logic [8:0] TC9 = 9'(TYPE_COUNT);

  logic    accept, advance, commit;
  logic    s1_valid_q, s1_valid_d;
  in_t     s1_q;
  logic    out_valid_q, out_valid_d;
  out_t    out_q, out_d;

  phase_e  phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] type_q, type_d;
  logic [7:0] left_q, left_d;
  logic [7:0] offs_q, offs_d;
  logic       lat_any_q, lat_any_d;
  logic [7:0] lat_size_q, lat_size_d;

  logic [7:0] rd_addr, chk_addr, c, tid;
  logic       c_in_range, tid_in_range, size_match, cnt_bad;
  logic [9:0] cnt_w;
  logic [7:0] cnt;
  logic [7:0] left_dec;
  tbl_wr_t    tbl_wr;
  slot_t      slot;
  status_e    status;
  logic [7:0] data_b, offs_b;

  // --- handshake ------------------------------------------------------------
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign commit     = s1_valid_q && advance;

  assign s1_valid_d = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_i;
    end
  end

  // --- table ----------------------------------------------------------------
  assign rd_addr  = (in_i.func == FUNC_BYTE) ? in_i.byte_value : in_i.type_id;
  assign c        = s1_q.byte_value;
  assign tid      = s1_q.type_id;
  assign chk_addr = (s1_q.func == FUNC_BYTE) ? c : tid;

  assign c_in_range   = {1'b0, c} < TC9;
  assign tid_in_range = {1'b0, tid} < TC9;

  always_comb begin
    tbl_wr.install  = commit && (s1_q.func == FUNC_INSTALL) && tid_in_range && !slot.used;
    tbl_wr.remove   = commit && (s1_q.func == FUNC_UNINSTALL) && tid_in_range && slot.used;
    tbl_wr.addr     = tid;
    tbl_wr.any_size = s1_q.any_size;
    tbl_wr.size     = s1_q.size_value;
  end

  spd_type_table #(
    .TYPE_COUNT(TYPE_COUNT)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .chk_addr_i(chk_addr),
    .wr_i      (tbl_wr),
    .slot_o    (slot)
  );

  // --- frame arithmetic -----------------------------------------------------
  assign size_match = lat_any_q || (lat_size_q == c);
  assign cnt_w      = {2'b00, c} + 10'(COUNT_ADJ);
  assign cnt_bad    = cnt_w[9] || (cnt_w == '0);
  assign cnt        = cnt_w[8] ? 8'hFF : cnt_w[7:0];
  assign left_dec   = left_q - 8'd1;

  // --- next state -----------------------------------------------------------
  always_comb begin
    phase_d    = phase_q;
    xor_d      = xor_q;
    type_d     = type_q;
    left_d     = left_q;
    offs_d     = offs_q;
    lat_any_d  = lat_any_q;
    lat_size_d = lat_size_q;
    if (commit && (s1_q.func == FUNC_BYTE)) begin
      case (phase_q)
        PH_SYNC_A: begin
          xor_d = '0;
          if (c == SYNC_A_BYTE) begin
            phase_d = PH_SYNC_B;
          end
        end
        PH_SYNC_B: begin
          if (c == SYNC_B_BYTE) begin
            phase_d = PH_TYPE;
            xor_d   = '0;
          end else begin
            phase_d = PH_SYNC_A;
          end
        end
        PH_TYPE: begin
          xor_d  = xor_q ^ c;
          type_d = c;
          if (!c_in_range) begin
            phase_d = PH_SYNC_A;
          end else begin
            lat_any_d  = slot.any_size;
            lat_size_d = slot.size;
            phase_d    = slot.used ? PH_SIZE : PH_SYNC_A;
          end
        end
        PH_SIZE: begin
          phase_d = PH_SYNC_A;
          if (size_match && !cnt_bad) begin
            xor_d   = xor_q ^ c;
            left_d  = cnt;
            offs_d  = FIRST_OFFSET;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          xor_d  = xor_q ^ c;
          offs_d = offs_q + 8'd1;
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_CHECK;
          end
        end
        default: begin
          phase_d = PH_SYNC_A;
        end
      endcase
    end
  end

  // --- result ---------------------------------------------------------------
  always_comb begin
    status = ST_RANGE;
    data_b = '0;
    offs_b = '0;
    case (s1_q.func)
      FUNC_BYTE: begin
        case (phase_q)
          PH_SYNC_A:  status = (c == SYNC_A_BYTE) ? ST_SYNCA : ST_UNSYNC;
          PH_SYNC_B:  status = (c == SYNC_B_BYTE) ? ST_SYNCB : ST_UNSYNC;
          PH_TYPE: begin
            if (!c_in_range) begin
              status = ST_UNSYNC;
            end else begin
              status = slot.used ? ST_TYPE : ST_UNKNOWN;
            end
          end
          PH_SIZE:    status = (size_match && !cnt_bad) ? ST_SIZE : ST_BADSIZE;
          PH_PAYLOAD: begin
            status = (left_dec == '0) ? ST_DONE : ST_PAYLOAD;
            data_b = c;
            offs_b = offs_q;
          end
          PH_CHECK:   status = (c == xor_q) ? ST_CRCOK : ST_CRCERR;
          default:    status = ST_UNSYNC;
        endcase
      end
      FUNC_INSTALL: begin
        if (!tid_in_range) begin
          status = ST_RANGE;
        end else begin
          status = slot.used ? ST_INSTERR : ST_OK;
        end
      end
      FUNC_UNINSTALL: begin
        if (!tid_in_range) begin
          status = ST_RANGE;
        end else begin
          status = slot.used ? ST_OK : ST_UNINSTERR;
        end
      end
      default: status = ST_RANGE;
    endcase
  end

  always_comb begin
    out_d.status      = status;
    out_d.data_byte   = data_b;
    out_d.byte_offset = offs_b;
    out_d.packet_type = type_d;
  end

  assign out_valid_d = commit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= PH_SYNC_A;
      xor_q       <= '0;
      type_q      <= '0;
      left_q      <= '0;
      offs_q      <= '0;
      lat_any_q   <= 1'b0;
      lat_size_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      xor_q       <= xor_d;
      type_q      <= type_d;
      left_q      <= left_d;
      offs_q      <= offs_d;
      lat_any_q   <= lat_any_d;
      lat_size_q  <= lat_size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // --- checks ---------------------------------------------------------------
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty commit stage");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed request not presented");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (left_q != '0))
    else $error("payload phase with no bytes left");

  a_done_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (status == ST_DONE)) |=> (phase_q == PH_CHECK))
    else $error("last payload byte did not reach checksum phase");

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync-word packet deframer.
// Line bytes and type-table edits go in over the valid/stall request channel.
// A behavioural copy of the frame walk and the type table predicts the status
// of every accepted request, and results are compared in order, field by
// field. Both sides idle at random. Most of the random traffic is well-formed
// frames with random content, mixed with table edits, broken headers and line
// noise.
// ----------------------------------------------------------------------------
module tb;
  import spd_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int ITEM_TARGET   = 1450;
  localparam int PAUSE_AT      = 700;
  localparam int LONG_HOLD_AT  = 300;
  localparam int LONG_HOLD     = 64;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;

  class frame_status_board;
    phase_e     frame_phase;
    logic [7:0] frame_xor;
    logic [7:0] last_type;
    logic [7:0] bytes_to_go;
    logic [7:0] next_offset;
    slot_t      type_slots[TYPE_COUNT_DEF];
    slot_t      held_slot;
    out_t       expected_status[$];
    int         failures;
    int         checked;

    function new();
      frame_phase = PH_SYNC_A;
      frame_xor   = '0;
      last_type   = '0;
      bytes_to_go = '0;
      next_offset = '0;
      foreach (type_slots[i]) type_slots[i] = '0;
      held_slot = '0;
      failures  = 0;
      checked   = 0;
    endfunction

    function out_t walk_request(in_t req);
      out_t       res;
      logic [7:0] b;
      int         tid;
      int         count;
      res = '0;
      b   = req.byte_value;
      tid = int'(req.type_id);
      case (req.func)
        FUNC_BYTE: begin
          case (frame_phase)
            PH_SYNC_A: begin
              frame_xor = '0;
              if (b == SYNC_A_BYTE) begin
                frame_phase = PH_SYNC_B;
                res.status  = ST_SYNCA;
              end else begin
                res.status = ST_UNSYNC;
              end
            end
            PH_SYNC_B: begin
              if (b == SYNC_B_BYTE) begin
                frame_phase = PH_TYPE;
                frame_xor   = '0;
                res.status  = ST_SYNCB;
              end else begin
                frame_phase = PH_SYNC_A;
                res.status  = ST_UNSYNC;
              end
            end
            PH_TYPE: begin
              frame_xor = frame_xor ^ b;
              last_type = b;
              if (int'(b) >= TYPE_COUNT_DEF) begin
                frame_phase = PH_SYNC_A;
                res.status  = ST_UNSYNC;
              end else begin
                // entry is latched here; later edits leave this packet alone
                held_slot = type_slots[int'(b)];
                if (!held_slot.used) begin
                  frame_phase = PH_SYNC_A;
                  res.status  = ST_UNKNOWN;
                end else begin
                  frame_phase = PH_SIZE;
                  res.status  = ST_TYPE;
                end
              end
            end
            PH_SIZE: begin
              frame_phase = PH_SYNC_A;
              count = int'(b) + COUNT_ADJ;
              if (!held_slot.any_size && held_slot.size != b) begin
                res.status = ST_BADSIZE;
              end else if (count < 1) begin
                res.status = ST_BADSIZE;
              end else begin
                if (count > 255) count = 255;
                frame_xor   = frame_xor ^ b;
                bytes_to_go = 8'(count);
                next_offset = FIRST_OFFSET;
                frame_phase = PH_PAYLOAD;
                res.status  = ST_SIZE;
              end
            end
            PH_PAYLOAD: begin
              frame_xor       = frame_xor ^ b;
              res.data_byte   = b;
              res.byte_offset = next_offset;
              next_offset     = next_offset + 8'd1;
              bytes_to_go     = bytes_to_go - 8'd1;
              if (bytes_to_go == 8'd0) begin
                frame_phase = PH_CHECK;
                res.status  = ST_DONE;
              end else begin
                res.status = ST_PAYLOAD;
              end
            end
            PH_CHECK: begin
              frame_phase = PH_SYNC_A;
              res.status  = (b == frame_xor) ? ST_CRCOK : ST_CRCERR;
            end
            default: begin
              frame_phase = PH_SYNC_A;
              res.status  = ST_UNSYNC;
            end
          endcase
        end
        FUNC_INSTALL: begin
          if (tid >= TYPE_COUNT_DEF) begin
            res.status = ST_RANGE;
          end else if (type_slots[tid].used) begin
            res.status = ST_INSTERR;
          end else begin
            type_slots[tid].used     = 1'b1;
            type_slots[tid].any_size = req.any_size;
            type_slots[tid].size     = req.size_value;
            res.status = ST_OK;
          end
        end
        FUNC_UNINSTALL: begin
          if (tid >= TYPE_COUNT_DEF) begin
            res.status = ST_RANGE;
          end else if (!type_slots[tid].used) begin
            res.status = ST_UNINSTERR;
          end else begin
            type_slots[tid] = '0;
            res.status = ST_OK;
          end
        end
        default: res.status = ST_RANGE;
      endcase
      res.packet_type = last_type;
      return res;
    endfunction

    function void note_request(in_t req);
      expected_status.push_back(walk_request(req));
    endfunction

    function void check_result(out_t got);
      out_t want;
      checked++;
      if (expected_status.size() == 0) begin
        $error("result %h with no request outstanding", got);
        failures++;
        return;
      end
      want = expected_status.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %h, actual %h", want.data_byte, got.data_byte);
        failures++;
      end
      if (got.byte_offset !== want.byte_offset) begin
        $error("byte_offset: expected %h, actual %h", want.byte_offset, got.byte_offset);
        failures++;
      end
      if (got.packet_type !== want.packet_type) begin
        $error("packet_type: expected %h, actual %h", want.packet_type, got.packet_type);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_status.size();
    endfunction

    function void close_out();
      if (expected_status.size() != 0) begin
        $error("%0d results never arrived", expected_status.size());
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni     = 1'b0;
  logic in_valid   = 1'b0;
  in_t  in_req     = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall  = 1'b0;
  out_t out_res;

  frame_status_board board = new();

  // generator's own view of the type table, kept in request order
  bit         type_used[TYPE_COUNT_DEF];
  bit         type_any[TYPE_COUNT_DEF];
  logic [7:0] type_size[TYPE_COUNT_DEF];

  int sent_count    = 0;
  int send_gap_max  = 5;

  sync_packet_deframer_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_res)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic in_t noisy_request();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(in_t)-1:0];
  endfunction

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_request(input in_t req);
    int gap;
    bit took;
    if ($urandom_range(0, 39) == 0) send_gap_max = (send_gap_max == 0) ? 5 : 0;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do begin
      @(negedge clk_i);
      took = !in_stall;
      if (took) board.note_request(req);
      @(posedge clk_i);
    end while (!took);
    sent_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_t req;
    req = noisy_request();
    req.func       = FUNC_BYTE;
    req.byte_value = b;
    send_request(req);
  endtask

  task automatic send_edit(input logic [1:0] func, input logic [7:0] tid,
                           input logic [7:0] len, input logic any);
    in_t req;
    int  idx;
    req = noisy_request();
    req.func       = func;
    req.type_id    = tid;
    req.size_value = len;
    req.any_size   = any;
    send_request(req);
    idx = int'(tid);
    if (idx < TYPE_COUNT_DEF) begin
      if (func == FUNC_INSTALL && !type_used[idx]) begin
        type_used[idx] = 1'b1;
        type_any[idx]  = any;
        type_size[idx] = len;
      end else if (func == FUNC_UNINSTALL) begin
        type_used[idx] = 1'b0;
      end
    end
  endtask

  task automatic random_edit();
    logic [1:0] func;
    logic [7:0] tid;
    logic [7:0] len;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) func = FUNC_SPARE;
    else if (pick < 52) func = FUNC_INSTALL;
    else func = FUNC_UNINSTALL;
    if ($urandom_range(0, 6) == 0) tid = 8'($urandom_range(TYPE_COUNT_DEF, 255));
    else tid = 8'($urandom_range(0, TYPE_COUNT_DEF - 1));
    if ($urandom_range(0, 19) == 0) len = 8'($urandom);
    else len = 8'($urandom_range(3, 12));
    send_edit(func, tid, len, $urandom_range(0, 2) == 0);
  endtask

  task automatic send_frame();
    logic [7:0] kind;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    int         pick;
    kind = 8'($urandom_range(0, TYPE_COUNT_DEF - 1));
    if (!type_used[int'(kind)])
      send_edit(FUNC_INSTALL, kind, 8'($urandom_range(3, 12)), $urandom_range(0, 2) == 0);
    if (type_any[int'(kind)]) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) len = 8'($urandom_range(128, 255));
      else if (pick < 8) len = 8'($urandom_range(0, 2));
      else len = 8'($urandom_range(3, 12));
    end else begin
      len = type_size[int'(kind)];
      // keep long fixed-size types mostly to a size error
      if (len > 8'd40 && $urandom_range(0, 9) != 0) len = 8'($urandom_range(3, 12));
      if ($urandom_range(0, 9) == 0) len = len ^ 8'($urandom_range(1, 255));
    end
    send_byte(SYNC_A_BYTE);
    send_byte(SYNC_B_BYTE);
    send_byte(kind);
    if ($urandom_range(0, 9) == 0) random_edit();
    send_byte(len);
    n   = int'(len) + COUNT_ADJ;
    sum = kind ^ len;
    for (int i = 0; i < n; i++) begin
      b   = 8'($urandom);
      sum = sum ^ b;
      send_byte(b);
      if ($urandom_range(0, 49) == 0) random_edit();
    end
    if ($urandom_range(0, 7) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic send_noise();
    int n;
    int pick;
    n = $urandom_range(1, 4);
    repeat (n) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) send_byte(SYNC_A_BYTE);
      else if (pick == 1) send_byte(SYNC_B_BYTE);
      else send_byte(8'($urandom));
    end
  endtask

  initial begin : stimulus
    bit paused;
    int pick;
    paused = 1'b0;
    foreach (type_size[i]) type_size[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_edit(FUNC_INSTALL, 8'd0, 8'd5, 1'b0);
    send_edit(FUNC_INSTALL, 8'd0, 8'd9, 1'b1);     // already installed
    send_edit(FUNC_UNINSTALL, 8'd7, 8'd0, 1'b0);   // free entry
    send_edit(FUNC_INSTALL, 8'hFF, 8'hFF, 1'b1);   // type out of range
    send_edit(FUNC_UNINSTALL, 8'd16, 8'd0, 1'b0);
    send_edit(FUNC_SPARE, 8'd1, 8'd1, 1'b0);
    send_edit(FUNC_INSTALL, 8'd15, 8'hFF, 1'b1);
    // type 0, size 5: three payload bytes, good checksum
    send_byte(SYNC_A_BYTE);
    send_byte(SYNC_B_BYTE);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7A);
    // any-size type, size too small for a payload
    send_byte(SYNC_A_BYTE);
    send_byte(SYNC_B_BYTE);
    send_byte(8'h0F);
    send_byte(8'h02);
    send_byte(SYNC_A_BYTE);
    send_byte(SYNC_B_BYTE);
    send_byte(8'hFF);
    send_byte(SYNC_A_BYTE);
    send_byte(SYNC_B_BYTE);
    send_byte(8'h03);
    send_byte(SYNC_A_BYTE);
    send_byte(8'h00);

    while (sent_count < ITEM_TARGET) begin
      if (!paused && sent_count >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (board.outstanding() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 62) send_frame();
      else if (pick < 76) random_edit();
      else if (pick < 88) begin
        send_byte(SYNC_A_BYTE);
        send_byte(SYNC_B_BYTE);
        send_byte(8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom));
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom));
      end else send_noise();
    end

    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    board.close_out();
    if (board.failures == 0) begin
      $display("sync_packet_deframer_top: match");
    end else begin
      $display("sync_packet_deframer_top: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    int hold;
    int sink_gap_max;
    bit got;
    bit long_done;
    sink_gap_max = 5;
    long_done    = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_gap_max = (sink_gap_max == 0) ? 5 : 0;
      hold = $urandom_range(0, sink_gap_max);
      // one long hold-off so the block backs up and stalls its input
      if (!long_done && board.checked >= LONG_HOLD_AT) begin
        hold      = LONG_HOLD;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk_i);
        got = out_valid;
        if (got) board.check_result(out_res);
        @(posedge clk_i);
      end while (!got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("sync_packet_deframer_top: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
